// ===== rtl/pdir_pkg.sv =====
// Shared types and constants for the pulse-distance IR transmitter.
// No dependencies; the top level and pdir_ctrl import this package.
package pdir_pkg;

    localparam int unsigned FRAME_W = 28;

    localparam logic [1:0] ACT_SEND_CMD = 2'd0;
    localparam logic [1:0] ACT_SEND_REG = 2'd1;
    localparam logic [1:0] ACT_ENV_TICK = 2'd2;
    localparam logic [1:0] ACT_MS_TICK  = 2'd3;

    localparam logic [1:0] REG_DEV_ADDR = 2'd0;
    localparam logic [1:0] REG_CMD_BASE = 2'd1;
    localparam logic [1:0] REG_COOLDOWN = 2'd2;

    localparam logic [3:0] DEV_ADDR_RST = 4'd7;
    localparam logic [7:0] CMD_BASE_RST = 8'd0;
    localparam logic [9:0] COOLDOWN_RST = 10'd100;

    localparam logic [2:0] START_BURST_UNITS = 3'd4;
    localparam logic [2:0] START_UNITS       = 3'd6;
    localparam logic [2:0] ZERO_BIT_UNITS    = 3'd3;
    localparam logic [2:0] ONE_BIT_UNITS     = 3'd4;
    localparam logic [4:0] TOP_BIT           = 5'd27;

    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_START    = 5'b00010,
        MODE_DATA     = 5'b00100,
        MODE_STOP     = 5'b01000,
        MODE_COOLDOWN = 5'b10000
    } mode_t;

    // Control from the sequencer to the row of frame bit cells.
    typedef struct packed {
        logic load;
        logic shift;
    } pdir_ctl_t;

endpackage

// ===== rtl/pulse_distance_ir_transmitter.sv =====
// Top level of the pulse-distance IR transmitter: handshake, registers, bit chain.
// Depends on pdir_pkg, pdir_cell and pdir_ctrl.
//
// Use: each input beat carries an action (send command, send register value,
// envelope tick, millisecond tick) with a command byte or register index and a
// 16-bit value. Every input beat yields exactly one output beat with the
// carrier enable, busy flag and whether a send request started a frame.
// The 28-bit frame sits in a row of bit cells; on each data-bit advance every
// cell takes its lower neighbor's bit, so the top cell is the bit on the wire.
// Latency: the result beat is valid the cycle after the input beat is taken.
// Throughput: one beat per cycle; the single output register lets a new
// input beat in whenever it is empty or is being taken in the same cycle.
// When the receiver stalls with a result pending, in_stall rises and the
// pending result holds until taken.
// Reset: sequencer idle with carrier off, no result pending, registers at device address 7,
// command base 0 and cooldown 100 ticks. Write registers over APB while idle.
module pulse_distance_ir_transmitter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  command_or_index,
    input  logic [15:0] payload_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        carrier_enable,
    output logic        busy_res,
    output logic        accepted,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pdir_pkg::*;

    logic [3:0]         dev_addr_reg;
    logic [7:0]         cmd_base_reg;
    logic [9:0]         cooldown_reg;
    logic               cfg_wr;

    logic               fire;
    logic               out_valid_reg, out_valid_next;
    logic               carrier_reg, busy_reg, accepted_reg;
    logic               carrier_nx, busy_nx, accepted_nx;
    logic [7:0]         cmd_byte;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] chain_q;
    pdir_ctl_t          ctl;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEV_ADDR_RST;
            cmd_base_reg <= CMD_BASE_RST;
            cooldown_reg <= COOLDOWN_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_DEV_ADDR: dev_addr_reg <= pwdata[3:0];
                REG_CMD_BASE: cmd_base_reg <= pwdata[7:0];
                REG_COOLDOWN: cooldown_reg <= pwdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DEV_ADDR: prdata = {28'd0, dev_addr_reg};
            REG_CMD_BASE: prdata = {24'd0, cmd_base_reg};
            REG_COOLDOWN: prdata = {22'd0, cooldown_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign in_stall = out_valid_reg & out_stall;
    assign fire     = in_valid & ~in_stall;

    assign cmd_byte = (action == ACT_SEND_REG) ? 8'(command_or_index + cmd_base_reg)
                                               : command_or_index;
    assign frame    = {cmd_byte, payload_value, dev_addr_reg};

    pdir_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .action          (action),
        .cooldown_ticks  (cooldown_reg),
        .cur_bit         (chain_q[FRAME_W-1]),
        .ctl             (ctl),
        .carrier_next_o  (carrier_nx),
        .busy_next_o     (busy_nx),
        .accepted_next_o (accepted_nx)
    );

    genvar gi;
    generate
        for (gi = 0; gi < FRAME_W; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                pdir_cell u_cell (
                    .clk      (clk),
                    .load     (ctl.load),
                    .shift    (ctl.shift),
                    .load_bit (frame[gi]),
                    .shift_in (1'b0),
                    .q        (chain_q[gi])
                );
            end
            else
            begin : g_rest
                pdir_cell u_cell (
                    .clk      (clk),
                    .load     (ctl.load),
                    .shift    (ctl.shift),
                    .load_bit (frame[gi]),
                    .shift_in (chain_q[gi-1]),
                    .q        (chain_q[gi])
                );
            end
        end
    endgenerate

    // hold a pending result while the receiver stalls
    assign out_valid_next = fire | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            carrier_reg  <= carrier_nx;
            busy_reg     <= busy_nx;
            accepted_reg <= accepted_nx;
        end
    end

    assign out_valid      = out_valid_reg;
    assign carrier_enable = carrier_reg;
    assign busy_res       = busy_reg;
    assign accepted       = accepted_reg;

endmodule

// ===== rtl/pdir_cell.sv =====
// One frame bit cell: loads its own frame bit or takes its lower neighbor's bit.
// Depends on nothing but the clock; the top level chains FRAME_W of these.
module pdir_cell (
    input  logic clk,
    input  logic load,
    input  logic shift,
    input  logic load_bit,
    input  logic shift_in,
    output logic q
);

    logic bit_reg;
    logic bit_next;

    always_comb
    begin
        bit_next = bit_reg;
        if (load)
        begin
            bit_next = load_bit;
        end
        else if (shift)
        begin
            bit_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    assign q = bit_reg;

endmodule

// ===== rtl/pdir_ctrl.sv =====
// Envelope sequencer: mode, unit and bit counters, cooldown counter, carrier.
// Depends on pdir_pkg; reads the top cell of the frame chain as the current bit.
module pdir_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [1:0]          action,
    input  logic [9:0]          cooldown_ticks,
    input  logic                cur_bit,
    output pdir_pkg::pdir_ctl_t ctl,
    output logic                carrier_next_o,
    output logic                busy_next_o,
    output logic                accepted_next_o
);
    import pdir_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [4:0] bit_pos_reg, bit_pos_next;
    logic [2:0] unit_reg, unit_next;
    logic [9:0] cool_reg, cool_next;
    logic       carrier_reg, carrier_next;
    logic [2:0] unit_p1;
    logic [2:0] bit_len;
    logic [9:0] cool_m1;

    assign unit_p1 = unit_reg + 3'd1;
    assign bit_len = cur_bit ? ONE_BIT_UNITS : ZERO_BIT_UNITS;
    assign cool_m1 = (cool_reg != 10'd0) ? (cool_reg - 10'd1) : cool_reg;

    always_comb
    begin
        mode_next       = mode_reg;
        bit_pos_next    = bit_pos_reg;
        unit_next       = unit_reg;
        cool_next       = cool_reg;
        carrier_next    = carrier_reg;
        ctl.load        = 1'b0;
        ctl.shift       = 1'b0;
        accepted_next_o = 1'b0;
        if (fire)
        begin
            unique case (action) inside
                ACT_SEND_CMD, ACT_SEND_REG:
                begin
                    // drop requests while a frame or cooldown is under way
                    if (mode_reg == MODE_IDLE)
                    begin
                        mode_next       = MODE_START;
                        unit_next       = 3'd0;
                        bit_pos_next    = 5'd0;
                        carrier_next    = 1'b1;
                        ctl.load        = 1'b1;
                        accepted_next_o = 1'b1;
                    end
                end
                ACT_ENV_TICK:
                begin
                    unique case (mode_reg)
                        MODE_START:
                        begin
                            if (unit_p1 < START_UNITS)
                            begin
                                unit_next    = unit_p1;
                                carrier_next = (unit_p1 < START_BURST_UNITS);
                            end
                            else
                            begin
                                mode_next    = MODE_DATA;
                                bit_pos_next = TOP_BIT;
                                unit_next    = 3'd0;
                                carrier_next = 1'b1;
                            end
                        end
                        MODE_DATA:
                        begin
                            if (unit_p1 < bit_len)
                            begin
                                unit_next    = unit_p1;
                                carrier_next = 1'b0;
                            end
                            else if (bit_pos_reg == 5'd0)
                            begin
                                mode_next    = MODE_STOP;
                                unit_next    = 3'd0;
                                carrier_next = 1'b1;
                            end
                            else
                            begin
                                // advance to the next lower frame bit
                                bit_pos_next = bit_pos_reg - 5'd1;
                                unit_next    = 3'd0;
                                carrier_next = 1'b1;
                                ctl.shift    = 1'b1;
                            end
                        end
                        MODE_STOP:
                        begin
                            carrier_next = 1'b0;
                            unit_next    = 3'd0;
                            if (cooldown_ticks == 10'd0)
                            begin
                                mode_next = MODE_IDLE;
                                cool_next = 10'd0;
                            end
                            else
                            begin
                                mode_next = MODE_COOLDOWN;
                                cool_next = cooldown_ticks;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                    if (mode_reg == MODE_COOLDOWN)
                    begin
                        cool_next = cool_m1;
                        if (cool_m1 == 10'd0)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            bit_pos_reg <= 5'd0;
            unit_reg    <= 3'd0;
            cool_reg    <= 10'd0;
            carrier_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            bit_pos_reg <= bit_pos_next;
            unit_reg    <= unit_next;
            cool_reg    <= cool_next;
            carrier_reg <= carrier_next;
        end
    end

    assign carrier_next_o = carrier_next;
    assign busy_next_o    = (mode_next != MODE_IDLE);

    a_carrier_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        carrier_reg |-> (mode_reg == MODE_START || mode_reg == MODE_DATA
                         || mode_reg == MODE_STOP))
        else $error("carrier on outside a frame");

    a_cooldown_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_COOLDOWN) |-> (cool_reg != 10'd0))
        else $error("cooldown mode with empty counter");

    a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> (mode_reg == MODE_START && carrier_reg && unit_reg == 3'd0))
        else $error("frame load did not start the start symbol");

    a_shift_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |-> (mode_reg == MODE_DATA && bit_pos_reg != 5'd0))
        else $error("frame shift outside data bits");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_DATA) |-> (unit_reg < ONE_BIT_UNITS))
        else $error("data unit counter out of range");

endmodule
